// ===== hdl/ipfd_pkg.sv =====
package ipfd_pkg;

   // Number of data intervals in one frame; the action key is the top byte.
   localparam int FRAME_BITS = 32;
   localparam int CNT_W      = $clog2(FRAME_BITS);

   // Field widths of the item channels and the register port.
   localparam int IV_W      = 16;
   localparam int CODE_W    = 32;
   localparam int KEY_W     = 8;
   localparam int DUTY_W    = 16;
   localparam int TONE_W    = 16;
   localparam int DSTEP_W   = 13;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 16;
   localparam int RSP_RAW_W = CODE_W + KEY_W + 1 + DUTY_W + 1 + TONE_W;
   localparam int RSP_W     = ((RSP_RAW_W + 7) / 8) * 8;

   // Register indexes on the write port.
   localparam logic [CSR_AW-1:0] REG_LEADER_MIN = 3'd0;
   localparam logic [CSR_AW-1:0] REG_LEADER_MAX = 3'd1;
   localparam logic [CSR_AW-1:0] REG_ZERO_MIN   = 3'd2;
   localparam logic [CSR_AW-1:0] REG_ZERO_MAX   = 3'd3;
   localparam logic [CSR_AW-1:0] REG_ONE_MIN    = 3'd4;
   localparam logic [CSR_AW-1:0] REG_ONE_MAX    = 3'd5;
   localparam logic [CSR_AW-1:0] REG_DUTY_STEP  = 3'd6;
   localparam logic [CSR_AW-1:0] REG_TONE_STEP  = 3'd7;

   // Interval windows used by the frame receiver.
   typedef struct packed {
      logic [IV_W-1:0] leader_min;
      logic [IV_W-1:0] leader_max;
      logic [IV_W-1:0] one_min;
      logic [IV_W-1:0] one_max;
   } win_type;

   // Frame receiver status toward the key action unit and the result register.
   typedef struct packed {
      logic              done;
      logic [CODE_W-1:0] code;
      logic [KEY_W-1:0]  key;
   } frame_type;

   // Output register values after a key action.
   typedef struct packed {
      logic              known;
      logic [DUTY_W-1:0] duty;
      logic              led;
      logic [TONE_W-1:0] tone;
   } act_type;

endpackage

// ===== hdl/ir_pulse_frame_decoder.sv =====
// Pulse-distance infrared frame decoder. Each item on the req_ channel is one measured
// edge-to-edge interval in timer ticks; a leader interval arms the decoder, the next
// interval is skipped as sync, and the following 32 intervals become code bits (inside
// the one window gives 1, first bit in bit 0). At frame end the top code byte drives the
// duty, LED and tone actions and one item carrying the code and the updated values
// appears on rsp_; intervals that do not end a frame give no item. The block takes one
// item per clock cycle while the output is not stalled: an item passes an input register
// and then window compare, key decode and small constant multiplies into the result
// register. The input register keeps taking an item while a result waits in the output
// register; it holds only when both are full. The user must write registers on the csr_
// port only while the block is idle; the block itself does not enforce this.
module ir_pulse_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // interval[15:0]
   input  logic [ipfd_pkg::IV_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // frame_code[31:0], key_byte[39:32], key_known[40], duty_value[56:41],
   // led_on[57], tone_compare[73:58], zero fill[79:74]
   output logic [ipfd_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_we,
   input  logic [ipfd_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [ipfd_pkg::CSR_DW-1:0]   csr_wdata
);

   ipfd_pkg::win_type                 win_ff, win_in;
   logic [ipfd_pkg::DSTEP_W-1:0]      duty_step_ff, duty_step_in;
   logic [ipfd_pkg::TONE_W-1:0]       tone_step_ff, tone_step_in;

   logic                              in_valid_ff, in_valid_in;
   logic [ipfd_pkg::IV_W-1:0]         interval_ff, interval_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ipfd_pkg::CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic [ipfd_pkg::KEY_W-1:0]        rsp_key_ff, rsp_key_in;
   ipfd_pkg::act_type                 rsp_act_ff, rsp_act_in;

   logic                              req_accept;
   logic                              advance;
   ipfd_pkg::frame_type               frame;
   ipfd_pkg::act_type                 act;

   // Register writes; the zero window has no effect on decoding and is not kept.
   always_comb begin
      win_in       = win_ff;
      duty_step_in = duty_step_ff;
      tone_step_in = tone_step_ff;
      if (csr_we) begin
         unique case (csr_addr)
            ipfd_pkg::REG_LEADER_MIN: win_in.leader_min = csr_wdata;
            ipfd_pkg::REG_LEADER_MAX: win_in.leader_max = csr_wdata;
            ipfd_pkg::REG_ONE_MIN:    win_in.one_min    = csr_wdata;
            ipfd_pkg::REG_ONE_MAX:    win_in.one_max    = csr_wdata;
            ipfd_pkg::REG_DUTY_STEP:  duty_step_in = csr_wdata[ipfd_pkg::DSTEP_W-1:0];
            ipfd_pkg::REG_TONE_STEP:  tone_step_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.leader_min <= 16'd13950;
         win_ff.leader_max <= 16'd14600;
         win_ff.one_min    <= 16'd2230;
         win_ff.one_max    <= 16'd2470;
         duty_step_ff      <= 13'd1047;
         tone_step_ff      <= 16'd116;
      end else begin
         win_ff       <= win_in;
         duty_step_ff <= duty_step_in;
         tone_step_ff <= tone_step_in;
      end
   end

   // The held item moves on when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      interval_in = interval_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         interval_in = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   ipfd_frame_rx u_frame_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .interval (interval_ff),
      .win      (win_ff),
      .frame    (frame)
   );

   ipfd_key_action u_key_action (
      .clock      (clock),
      .reset      (reset),
      .frame_done (frame.done),
      .key        (frame.key),
      .duty_step  (duty_step_ff),
      .tone_step  (tone_step_ff),
      .act        (act)
   );

   // Result register, loaded only when a frame completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_act_in   = rsp_act_ff;
      if (frame.done) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = frame.code;
         rsp_key_in   = frame.key;
         rsp_act_in   = act;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      interval_ff <= interval_in;
      rsp_code_ff <= rsp_code_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_act_ff  <= rsp_act_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      (ipfd_pkg::RSP_W - ipfd_pkg::RSP_RAW_W)'(0),
      rsp_act_ff.tone,
      rsp_act_ff.led,
      rsp_act_ff.duty,
      rsp_act_ff.known,
      rsp_key_ff,
      rsp_code_ff
   };

`ifndef NO_ASSERTIONS
   // A frame can only finish while the held item is moving on.
   a_done_on_advance: assert property (@(posedge clock) disable iff (reset)
      frame.done |-> advance)
      else $error("frame completed without an advancing item");

   // A finished frame always lands in the result register.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      frame.done |=> rsp_valid_ff && (rsp_code_ff == $past(frame.code)))
      else $error("completed frame not loaded into the result register");

   // A held item that cannot move stays in the input register unchanged.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(interval_ff))
      else $error("stalled input item lost or changed");
`endif

endmodule

// ===== hdl/ipfd_frame_rx.sv =====
module ipfd_frame_rx (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [ipfd_pkg::IV_W-1:0]  interval,
   input  ipfd_pkg::win_type          win,
   output ipfd_pkg::frame_type        frame
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SYNC = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [ipfd_pkg::CNT_W-1:0] LAST_BIT =
      ipfd_pkg::CNT_W'(ipfd_pkg::FRAME_BITS - 1);

   logic [1:0]                        phase_ff, phase_in;
   logic [ipfd_pkg::CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [ipfd_pkg::FRAME_BITS-1:0]   code_ff, code_in;
   logic                              is_leader;
   logic                              is_one;
   logic                              done;

   // Window checks; all bounds are exclusive.
   assign is_leader = (interval > win.leader_min) && (interval < win.leader_max);
   assign is_one    = (interval > win.one_min) && (interval < win.one_max);

   // Phase sequencing and bit assembly, first bit into bit 0.
   always_comb begin
      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      code_in    = code_ff;
      done       = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_SYNC: begin
               // The sync edge is dropped and the frame starts clean.
               phase_in   = PH_DATA;
               bit_cnt_in = '0;
               code_in    = '0;
            end
            PH_DATA: begin
               if (is_one) begin
                  code_in[bit_cnt_ff] = 1'b1;
               end
               if (bit_cnt_ff == LAST_BIT) begin
                  phase_in   = PH_IDLE;
                  bit_cnt_in = '0;
                  done       = 1'b1;
               end else begin
                  bit_cnt_in = ipfd_pkg::CNT_W'(bit_cnt_ff + 1'b1);
               end
            end
            default: begin
               // Idle, and the unused code behaves as idle.
               phase_in = is_leader ? PH_SYNC : PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_cnt_ff <= '0;
         code_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         bit_cnt_ff <= bit_cnt_in;
         code_ff    <= code_in;
      end
   end

   assign frame.done = done;
   assign frame.code = ipfd_pkg::CODE_W'(code_in);
   assign frame.key  = code_in[ipfd_pkg::FRAME_BITS-1 -: ipfd_pkg::KEY_W];

`ifndef NO_ASSERTIONS
   // A frame only completes on the last data interval.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      done |-> (phase_ff == PH_DATA) && (bit_cnt_ff == LAST_BIT))
      else $error("frame completed outside the last data interval");

   // The interval after the sync edge starts at bit zero with a clear code.
   a_sync_clear: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_SYNC) |=>
         (phase_ff == PH_DATA) && (bit_cnt_ff == '0) && (code_ff == '0))
      else $error("data phase did not start clean after sync");

   // After a completed frame the receiver waits for a new leader.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (phase_ff == PH_IDLE) && (bit_cnt_ff == '0))
      else $error("receiver not idle after frame end");
`endif

endmodule

// ===== hdl/ipfd_key_action.sv =====
module ipfd_key_action (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          frame_done,
   input  logic [ipfd_pkg::KEY_W-1:0]    key,
   input  logic [ipfd_pkg::DSTEP_W-1:0]  duty_step,
   input  logic [ipfd_pkg::TONE_W-1:0]   tone_step,
   output ipfd_pkg::act_type             act
);

   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_A5 = 8'hA5;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_AD = 8'hAD;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_B8 = 8'hB8;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_B9 = 8'hB9;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_BA = 8'hBA;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_BB = 8'hBB;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_BC = 8'hBC;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_BF = 8'hBF;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_E3 = 8'hE3;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_E6 = 8'hE6;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_E7 = 8'hE7;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_E9 = 8'hE9;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_EA = 8'hEA;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_F2 = 8'hF2;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_F6 = 8'hF6;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_F7 = 8'hF7;
   localparam logic [ipfd_pkg::KEY_W-1:0] KEY_F8 = 8'hF8;

   localparam logic [ipfd_pkg::TONE_W-1:0] TONE_LOW  = 16'd524;
   localparam logic [ipfd_pkg::TONE_W-1:0] TONE_HIGH = 16'd2621;
   localparam logic [ipfd_pkg::TONE_W-1:0] TONE_MID  = 16'd1572;

   // Duty step times a small level, wrapped to the duty width.
   function automatic logic [ipfd_pkg::DUTY_W-1:0] duty_times(
      input logic [ipfd_pkg::DSTEP_W-1:0] s,
      input logic [3:0]                   k
   );
      logic [ipfd_pkg::DSTEP_W+3:0] p;
      p = s * k;
      return p[ipfd_pkg::DUTY_W-1:0];
   endfunction

   logic [ipfd_pkg::DUTY_W-1:0] duty_ff, duty_in;
   logic                        led_ff, led_in;
   logic [ipfd_pkg::TONE_W-1:0] tone_ff, tone_in;
   logic                        known;
   logic [ipfd_pkg::TONE_W-1:0] tone_up;
   logic [ipfd_pkg::TONE_W-1:0] tone_down;
   logic [ipfd_pkg::DUTY_W-1:0] duty_comp;

   assign tone_up   = ipfd_pkg::TONE_W'(tone_ff + tone_step);
   assign tone_down = ipfd_pkg::TONE_W'(tone_ff - tone_step);
   assign duty_comp = ipfd_pkg::DUTY_W'(duty_times(duty_step, 4'd10) - duty_ff);

   // Key decoder; an unknown key leaves every register as it was.
   always_comb begin
      duty_in = duty_ff;
      led_in  = led_ff;
      tone_in = tone_ff;
      known   = 1'b0;
      if (frame_done) begin
         known = 1'b1;
         unique case (key) inside
            KEY_F2: duty_in = duty_times(duty_step, 4'd1);
            KEY_E6: duty_in = duty_times(duty_step, 4'd3);
            KEY_F7: duty_in = duty_times(duty_step, 4'd4);
            KEY_E3: duty_in = duty_times(duty_step, 4'd5);
            KEY_A5: duty_in = duty_times(duty_step, 4'd6);
            KEY_BB: duty_in = duty_times(duty_step, 4'd10);
            KEY_BF, KEY_E9: duty_in = '0;
            KEY_BC: duty_in = duty_comp;
            KEY_E7: begin
               duty_in = duty_times(duty_step, 4'd2);
               if (tone_ff != TONE_HIGH) begin
                  tone_in = tone_up;
               end
            end
            KEY_AD: begin
               duty_in = duty_times(duty_step, 4'd8);
               if (tone_ff != TONE_LOW) begin
                  tone_in = tone_down;
               end
            end
            KEY_F6: begin
               duty_in = duty_times(duty_step, 4'd7);
               tone_in = TONE_HIGH;
            end
            KEY_EA: begin
               duty_in = duty_times(duty_step, 4'd9);
               tone_in = TONE_MID;
            end
            KEY_F8: tone_in = TONE_LOW;
            KEY_B8: led_in  = ~led_ff;
            KEY_B9: led_in  = 1'b0;
            KEY_BA: led_in  = 1'b1;
            default: known  = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
         led_ff  <= 1'b0;
         tone_ff <= '0;
      end else begin
         duty_ff <= duty_in;
         led_ff  <= led_in;
         tone_ff <= tone_in;
      end
   end

   assign act.known = known;
   assign act.duty  = duty_in;
   assign act.led   = led_in;
   assign act.tone  = tone_in;

endmodule
